[hdl/zph_pkg.sv]
// ----------------------------------------------------------------------------
// zph_pkg: Zobrist position hash package
// Key table generation, key types and table layout constants.
// ----------------------------------------------------------------------------
package zph_pkg;

	localparam int KEY_COUNT    = 793;
	localparam int KIND_COUNT   = 6;
	localparam int SQUARE_COUNT = 64;
	localparam int GROUP_COUNT  = 2 * KIND_COUNT;
	localparam int CASTLE_BASE  = 768;
	localparam int CASTLE_COUNT = 16;
	localparam int PASSANT_BASE = 784;
	localparam int PASSANT_COUNT = 8;
	localparam int SIDE_BASE    = 792;
	localparam logic [31:0] GEN_SEED = 32'd1804289383;

	localparam int HASH_W    = 64;
	localparam int BOARD_W   = 64;
	localparam int CASTLE_W  = 4;
	localparam int PASSANT_W = 6;

	typedef logic [HASH_W-1:0]  key_t;
	typedef logic [BOARD_W-1:0] board_t;
	typedef logic [KEY_COUNT-1:0][HASH_W-1:0]     key_table_t;
	typedef logic [CASTLE_COUNT-1:0][HASH_W-1:0]  castle_keys_t;
	typedef logic [PASSANT_COUNT-1:0][HASH_W-1:0] passant_keys_t;

	// Build the key table in table order: xorshift32 draws, four 16-bit
	// draws to a word, three words ANDed to a key.
	function automatic key_table_t gen_key_table();
		key_table_t  t;
		logic [31:0] st;
		key_t        w;
		key_t        k;
		st = GEN_SEED;
		t  = '0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			k = '1;
			for (int j = 0; j < 3; j++) begin
				w = '0;
				for (int d = 0; d < 4; d++) begin
					st = st ^ (st << 13);
					st = st ^ (st >> 17);
					st = st ^ (st << 5);
					w[16*d +: 16] = st[15:0];
				end
				k = k & w;
			end
			t[i] = k;
		end
		return t;
	endfunction

	localparam key_table_t KEY_TABLE = gen_key_table();

	function automatic castle_keys_t pick_castle_keys(key_table_t t);
		castle_keys_t c;
		for (int i = 0; i < CASTLE_COUNT; i++) begin
			c[i] = t[CASTLE_BASE + i];
		end
		return c;
	endfunction

	function automatic passant_keys_t pick_passant_keys(key_table_t t);
		passant_keys_t p;
		for (int i = 0; i < PASSANT_COUNT; i++) begin
			p[i] = t[PASSANT_BASE + i];
		end
		return p;
	endfunction

	localparam castle_keys_t  CASTLE_KEYS  = pick_castle_keys(KEY_TABLE);
	localparam passant_keys_t PASSANT_KEYS = pick_passant_keys(KEY_TABLE);
	localparam key_t          SIDE_KEY     = KEY_TABLE[SIDE_BASE];

endpackage

[hdl/zph_if.sv]
// ----------------------------------------------------------------------------
// zph_if: Zobrist position hash channels
// Position channel and hash channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface zph_pos_if;
	import zph_pkg::*;

	logic                 valid;
	logic                 ready;
	board_t               piece_kind0_bits;
	board_t               piece_kind1_bits;
	board_t               piece_kind2_bits;
	board_t               piece_kind3_bits;
	board_t               piece_kind4_bits;
	board_t               piece_kind5_bits;
	board_t               white_bits;
	board_t               black_bits;
	logic [CASTLE_W-1:0]  castle_rights;
	logic [PASSANT_W-1:0] passant_square;
	logic                 black_to_move;

	modport source (
		output valid, piece_kind0_bits, piece_kind1_bits, piece_kind2_bits,
		       piece_kind3_bits, piece_kind4_bits, piece_kind5_bits,
		       white_bits, black_bits, castle_rights, passant_square, black_to_move,
		input  ready
	);
	modport sink (
		input  valid, piece_kind0_bits, piece_kind1_bits, piece_kind2_bits,
		       piece_kind3_bits, piece_kind4_bits, piece_kind5_bits,
		       white_bits, black_bits, castle_rights, passant_square, black_to_move,
		output ready
	);
endinterface

interface zph_hash_if;
	import zph_pkg::*;

	logic valid;
	logic ready;
	key_t position_hash;

	modport source (output valid, position_hash, input ready);
	modport sink (input valid, position_hash, output ready);
endinterface

[hdl/zobrist_position_hash_top.sv]
// ----------------------------------------------------------------------------
// zobrist_position_hash_top: Zobrist position hash
// Three-stage AND-XOR pipeline over the fixed 793-entry key table.
// ----------------------------------------------------------------------------
// Usage:
//   pos  (sink)   : one chess position per transfer - six piece bitboards,
//                   two colour bitboards, castling rights, en-passant square
//                   and side to move.
//   hash (source) : one 64-bit Zobrist hash per position, in arrival order.
//   A pos transfer loads the select stage, then moves on through the
//   partial XOR stage to the final XOR stage, which drives hash.valid.
//   Throughput is one position per cycle while hash.ready is high; the
//   rate is set by the three register stages (select, 64-key partial XOR
//   per colour/kind group, final XOR), each of which takes a new item in
//   every cycle it is free.
//   Keys are constants built at elaboration, so the block is ready to run
//   as soon as reset is released; reset only clears the stage valid bits.
//   When the receiver stalls, the result holds in the last stage and each
//   earlier stage holds once the stage after it is full; empty stages
//   keep filling, so up to three positions are in flight. pos.ready drops
//   only when all three stages are full and hash.ready is low.
// ----------------------------------------------------------------------------
module zobrist_position_hash_top (
	input  logic           clk,
	input  logic           arst_n,
	zph_pos_if.sink        pos,
	zph_hash_if.source     hash
);
	import zph_pkg::*;

	// Stage 1: per colour/kind square selects, plus the small fields.
	logic                                   valid_s1;
	logic [GROUP_COUNT-1:0][BOARD_W-1:0]    sel_s1;
	logic [CASTLE_W-1:0]                    castle_s1;
	logic [PASSANT_W-1:0]                   passant_s1;
	logic                                   side_s1;

	// Stage 2: one partial hash per group, and one for castle/passant/side.
	logic                                   valid_s2;
	logic [GROUP_COUNT:0][HASH_W-1:0]       part_s2;

	// Stage 3: the finished hash, which is the output register.
	logic                                   valid_s3;
	key_t                                   hash_s3;

	logic                                   rdy_s1;
	logic                                   rdy_s2;
	logic                                   rdy_s3;

	logic [KIND_COUNT-1:0][BOARD_W-1:0]     kinds;
	logic [GROUP_COUNT-1:0][BOARD_W-1:0]    sel_d;
	logic [GROUP_COUNT:0][HASH_W-1:0]       part_d;
	key_t                                   hash_d;

	// A stage takes a new item when it is empty or its item moves on.
	assign rdy_s3    = !valid_s3 || hash.ready;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign pos.ready = rdy_s1;

	assign hash.valid         = valid_s3;
	assign hash.position_hash = hash_s3;

	// Mask each piece bitboard with each colour; white groups first.
	always_comb begin
		kinds[0] = pos.piece_kind0_bits;
		kinds[1] = pos.piece_kind1_bits;
		kinds[2] = pos.piece_kind2_bits;
		kinds[3] = pos.piece_kind3_bits;
		kinds[4] = pos.piece_kind4_bits;
		kinds[5] = pos.piece_kind5_bits;
		for (int p = 0; p < KIND_COUNT; p++) begin
			sel_d[p]              = kinds[p] & pos.white_bits;
			sel_d[KIND_COUNT + p] = kinds[p] & pos.black_bits;
		end
	end

	// XOR the keys of the selected squares, one group of 64 per partial.
	// The extra partial folds in castling, en-passant file and side keys.
	always_comb begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			part_d[g] = '0;
			for (int s = 0; s < SQUARE_COUNT; s++) begin
				if (sel_s1[g][s]) begin
					part_d[g] = part_d[g] ^ KEY_TABLE[g * SQUARE_COUNT + s];
				end
			end
		end
		part_d[GROUP_COUNT] = CASTLE_KEYS[castle_s1];
		if (passant_s1 != '0) begin
			part_d[GROUP_COUNT] = part_d[GROUP_COUNT] ^ PASSANT_KEYS[passant_s1[2:0]];
		end
		if (side_s1) begin
			part_d[GROUP_COUNT] = part_d[GROUP_COUNT] ^ SIDE_KEY;
		end
	end

	// Fold the partials into the final hash.
	always_comb begin
		hash_d = '0;
		for (int g = 0; g <= GROUP_COUNT; g++) begin
			hash_d = hash_d ^ part_s2[g];
		end
	end

	// Valid bits: advance when the stage is free, drop when the item leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= pos.valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Payload: load with the stage, hold while it is stalled.
	always_ff @(posedge clk) begin
		if (rdy_s1 && pos.valid) begin
			sel_s1     <= sel_d;
			castle_s1  <= pos.castle_rights;
			passant_s1 <= pos.passant_square;
			side_s1    <= pos.black_to_move;
		end
		if (rdy_s2 && valid_s1) begin
			part_s2 <= part_d;
		end
		if (rdy_s3 && valid_s2) begin
			hash_s3 <= hash_d;
		end
	end

	// An item in stage 2 that may move on shows up at the output next cycle.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rdy_s3) |=> hash.valid)
		else $error("stage 2 item did not reach the output");

	// A stalled stage 1 item holds its contents.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !rdy_s2) |=> (valid_s1 && $stable(sel_s1)
			&& $stable(castle_s1) && $stable(passant_s1) && $stable(side_s1)))
		else $error("stalled stage 1 item changed");

	// An empty first stage always takes input.
	a_s1_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pos.ready)
		else $error("input blocked with stage 1 empty");

	// An accepted position sits in stage 1 on the next cycle.
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pos.valid && pos.ready) |=> valid_s1)
		else $error("accepted position lost at stage 1");

endmodule

[tb/tb_zobrist_position_hash_top.sv]
// ----------------------------------------------------------------------------
// tb_zobrist_position_hash_top: Zobrist position hash testbench
// Drives chess positions into the hash pipeline with random idle gaps on both
// channels and compares every returned hash with a locally computed one. The
// key table is rebuilt here from the xorshift sequence.
// ----------------------------------------------------------------------------
module tb_zobrist_position_hash_top;
	timeunit 1ns;
	timeprecision 1ps;

	import zph_pkg::*;

	localparam int          CLK_HALF         = 10;
	localparam int          RESET_CYCLES     = 8;
	localparam int          PIPE_DEPTH       = 3;
	localparam int          LONG_HOLD_CYCLES = 60;
	localparam int unsigned CYCLE_LIMIT      = 200000;
	localparam int          RANDOM_ITEMS     = 1500;
	localparam int          STREAM_ITEMS     = 80;
	localparam logic [31:0] XS_SEED          = 32'd1804289383;

	// One position as the pos channel carries it
	typedef struct packed {
		logic [KIND_COUNT-1:0][BOARD_W-1:0] kind_bits;
		board_t                             white_bits;
		board_t                             black_bits;
		logic [CASTLE_W-1:0]                castle_rights;
		logic [PASSANT_W-1:0]               passant_square;
		logic                               black_to_move;
	} position_t;

	logic clk;
	logic arst_n;

	zph_pos_if  pos_ch ();
	zph_hash_if hash_ch ();

	zobrist_position_hash_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pos    (pos_ch),
		.hash   (hash_ch)
	);

	// Local copy of the fixed keys, filled before the first transfer
	key_t        zobrist_keys [KEY_COUNT];
	// Hashes still owed by the block, oldest first
	key_t        expected_hashes [$];
	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;

	// Receiver controls, set by the test tasks and read by the hash sink
	bit rx_no_idle   = 1'b0;
	bit rx_long_hold = 1'b0;

	// ------------------------------------------------------------------------
	// Key table and hash prediction
	// ------------------------------------------------------------------------
	function automatic logic [31:0] xorshift_next(input logic [31:0] s);
		s = s ^ (s << 13);
		s = s ^ (s >> 17);
		s = s ^ (s << 5);
		return s;
	endfunction

	// Each key is the AND of three words; each word packs four 16-bit draws,
	// lowest draw in the lowest bits.
	task automatic build_zobrist_keys();
		logic [31:0] st;
		key_t        word;
		key_t        acc;
		st = XS_SEED;
		for (int i = 0; i < KEY_COUNT; i++) begin
			acc = '1;
			for (int w = 0; w < 3; w++) begin
				word = '0;
				for (int q = 0; q < 4; q++) begin
					st = xorshift_next(st);
					word[16*q +: 16] = st[15:0];
				end
				acc = acc & word;
			end
			zobrist_keys[i] = acc;
		end
	endtask

	// Fold in one key per (colour, kind, square) hit, then castling, the
	// en-passant file (square zero means none) and the side to move.
	function automatic key_t zobrist_of(input position_t p);
		key_t   h;
		board_t side;
		board_t hits;
		h = '0;
		for (int colour = 0; colour < 2; colour++) begin
			side = (colour == 0) ? p.white_bits : p.black_bits;
			for (int kind = 0; kind < KIND_COUNT; kind++) begin
				hits = p.kind_bits[kind] & side;
				for (int sq = 0; sq < SQUARE_COUNT; sq++) begin
					if (hits[sq])
						h ^= zobrist_keys[(colour*KIND_COUNT + kind)*SQUARE_COUNT + sq];
				end
			end
		end
		h ^= zobrist_keys[CASTLE_BASE + p.castle_rights];
		if (p.passant_square != '0)
			h ^= zobrist_keys[PASSANT_BASE + p.passant_square[2:0]];
		if (p.black_to_move)
			h ^= zobrist_keys[SIDE_BASE];
		return h;
	endfunction

	// ------------------------------------------------------------------------
	// Position generators
	// ------------------------------------------------------------------------
	function automatic int unsigned idle_draw();
		return $urandom_range(0, 9);
	endfunction

	function automatic void random_trailer(inout position_t p);
		p.castle_rights  = CASTLE_W'($urandom_range(0, CASTLE_COUNT-1));
		// Keep "no en-passant" common, otherwise any square
		p.passant_square = ($urandom_range(0, 3) == 0) ? '0
		                                                : PASSANT_W'($urandom_range(0, 63));
		p.black_to_move  = 1'($urandom_range(0, 1));
	endfunction

	// Game-like board: each square empty or one piece of one colour, with the
	// occupancy drawn per position so both sparse and crowded boards appear.
	function automatic position_t random_game_position();
		position_t   p;
		int unsigned density;
		int unsigned piece;
		p = '0;
		density = $urandom_range(0, 100);
		for (int sq = 0; sq < SQUARE_COUNT; sq++) begin
			if ($urandom_range(0, 99) < density) begin
				piece = $urandom_range(0, GROUP_COUNT-1);
				p.kind_bits[piece % KIND_COUNT][sq] = 1'b1;
				if (piece < KIND_COUNT)
					p.white_bits[sq] = 1'b1;
				else
					p.black_bits[sq] = 1'b1;
			end
		end
		random_trailer(p);
		return p;
	endfunction

	// Arbitrary bitboards: overlapping colours and kinds, every bit free
	function automatic position_t random_raw_position();
		position_t p;
		p = '0;
		for (int k = 0; k < KIND_COUNT; k++)
			p.kind_bits[k] = {$urandom, $urandom};
		p.white_bits = {$urandom, $urandom};
		p.black_bits = {$urandom, $urandom};
		random_trailer(p);
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Position sender
	// ------------------------------------------------------------------------
	// Idle for gap cycles, offer the position, hold it until the transfer and
	// queue its hash. Valid stays high after the transfer until the next call
	// (or a drain) decides at the following falling edge.
	task automatic send_position(input position_t p, input int unsigned gap);
		@(negedge clk);
		if (gap != 0) begin
			pos_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pos_ch.piece_kind0_bits <= p.kind_bits[0];
		pos_ch.piece_kind1_bits <= p.kind_bits[1];
		pos_ch.piece_kind2_bits <= p.kind_bits[2];
		pos_ch.piece_kind3_bits <= p.kind_bits[3];
		pos_ch.piece_kind4_bits <= p.kind_bits[4];
		pos_ch.piece_kind5_bits <= p.kind_bits[5];
		pos_ch.white_bits       <= p.white_bits;
		pos_ch.black_bits       <= p.black_bits;
		pos_ch.castle_rights    <= p.castle_rights;
		pos_ch.passant_square   <= p.passant_square;
		pos_ch.black_to_move    <= p.black_to_move;
		pos_ch.valid            <= 1'b1;
		do @(posedge clk); while (!pos_ch.ready);
		expected_hashes.push_back(zobrist_of(p));
	endtask

	// Drop valid and wait until every queued hash has come back
	task automatic wait_hashes_drained();
		@(negedge clk);
		pos_ch.valid <= 1'b0;
		while (expected_hashes.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Field extremes and the corner cases of the hash definition
	task automatic test_directed_positions();
		position_t p;

		// Empty board: only the castling key for rights zero
		p = '0;
		send_position(p, idle_draw());

		// Everything set: every square in both colours and all six kinds,
		// all castling rights, last square as en-passant, black to move
		p = '1;
		send_position(p, idle_draw());

		// Single pieces at the board corners
		p = '0;
		p.kind_bits[0][0] = 1'b1;
		p.white_bits[0]   = 1'b1;
		send_position(p, idle_draw());
		p = '0;
		p.kind_bits[5][63] = 1'b1;
		p.black_bits[63]   = 1'b1;
		send_position(p, idle_draw());

		// Square in both colours: white and black key both fold in
		p = '0;
		p.kind_bits[3][27] = 1'b1;
		p.white_bits[27]   = 1'b1;
		p.black_bits[27]   = 1'b1;
		send_position(p, idle_draw());

		// Square in several kinds: one key per kind
		p = '0;
		p.kind_bits[1][40] = 1'b1;
		p.kind_bits[2][40] = 1'b1;
		p.kind_bits[4][40] = 1'b1;
		p.white_bits[40]   = 1'b1;
		send_position(p, idle_draw());

		// Colours without pieces, and pieces without colours: no square keys
		p = '0;
		p.white_bits = '1;
		p.black_bits = '1;
		send_position(p, idle_draw());
		p = '0;
		p.kind_bits = '1;
		send_position(p, idle_draw());

		// All castling rights with black to move and no en-passant
		p = '0;
		p.castle_rights = '1;
		p.black_to_move = 1'b1;
		send_position(p, idle_draw());

		// En-passant squares: first nonzero, file wrap at 8, last of a rank,
		// last square; square zero stays "none"
		p = '0;
		p.passant_square = 6'd1;
		send_position(p, idle_draw());
		p.passant_square = 6'd8;
		send_position(p, idle_draw());
		p.passant_square = 6'd7;
		send_position(p, idle_draw());
		p.passant_square = 6'd63;
		p.castle_rights  = 4'd5;
		send_position(p, idle_draw());
		p.passant_square = '0;
		p.castle_rights  = 4'd10;
		p.black_to_move  = 1'b1;
		send_position(p, idle_draw());
	endtask

	// Back-to-back transfers with the receiver never idling
	task automatic test_streaming(input int count);
		rx_no_idle = 1'b1;
		for (int i = 0; i < count; i++)
			send_position(($urandom_range(0, 3) == 0) ? random_raw_position()
			                                           : random_game_position(), 0);
		rx_no_idle = 1'b0;
	endtask

	// Receiver holds off for a long stretch while positions keep coming, so
	// all three stages fill and pos.ready drops.
	task automatic test_receiver_backpressure();
		rx_long_hold = 1'b1;
		for (int i = 0; i < 24; i++)
			send_position(random_game_position(), 0);
	endtask

	// Sender goes quiet until the pipeline has emptied, then restarts
	task automatic test_sender_pause();
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 8; i++)
				send_position(random_game_position(), idle_draw());
			wait_hashes_drained();
		end
	endtask

	// Mostly game-like boards, some raw noise
	task automatic test_random_positions(input int count);
		for (int i = 0; i < count; i++)
			send_position(($urandom_range(0, 9) < 8) ? random_game_position()
			                                          : random_raw_position(),
			              idle_draw());
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset and test sequence
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		// Hold every block input at a known value from time zero
		arst_n                  = 1'b0;
		pos_ch.valid            = 1'b0;
		pos_ch.piece_kind0_bits = '0;
		pos_ch.piece_kind1_bits = '0;
		pos_ch.piece_kind2_bits = '0;
		pos_ch.piece_kind3_bits = '0;
		pos_ch.piece_kind4_bits = '0;
		pos_ch.piece_kind5_bits = '0;
		pos_ch.white_bits       = '0;
		pos_ch.black_bits       = '0;
		pos_ch.castle_rights    = '0;
		pos_ch.passant_square   = '0;
		pos_ch.black_to_move    = 1'b0;
		build_zobrist_keys();

		// Keys are constants in the block, so no clearing pass follows reset
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_positions();
		test_streaming(STREAM_ITEMS);
		test_receiver_backpressure();
		test_sender_pause();
		test_random_positions(RANDOM_ITEMS);

		// Let the last hashes out, then a few more cycles for stray results
		wait_hashes_drained();
		repeat (PIPE_DEPTH + 5) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Hash receiver: draw a stall per result, skip it or take the long hold-off
	// when a test asks for it, then keep ready high until one transfer.
	// ------------------------------------------------------------------------
	initial begin : hash_sink
		int unsigned stall;
		hash_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_long_hold) begin
				rx_long_hold = 1'b0;
				stall        = LONG_HOLD_CYCLES;
			end else if (rx_no_idle) begin
				stall = 0;
			end else begin
				stall = idle_draw();
			end
			if (stall != 0) begin
				hash_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			hash_ch.ready <= 1'b1;
			do @(posedge clk); while (!(hash_ch.valid && hash_ch.ready));
		end
	end

	// ------------------------------------------------------------------------
	// Hash checker: every transfer must match the oldest queued hash
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : hash_check
		key_t want;
		if (arst_n && hash_ch.valid && hash_ch.ready) begin
			if (expected_hashes.size() == 0) begin
				mismatch_count++;
				$error("position_hash: expected none pending, actual %h",
				       hash_ch.position_hash);
			end else begin
				want = expected_hashes.pop_front();
				if (hash_ch.position_hash !== want) begin
					mismatch_count++;
					$error("position_hash: expected %h, actual %h",
					       want, hash_ch.position_hash);
				end
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
